// ===== sv/tsp_pkg.sv =====
// Package for the tagged slot pool: command and status codes, slot states
// and the item types carried on the command and response channels.
// Depends on nothing; every other file of the block but tsp_ram uses it.
package tsp_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_FULL       = 2'd1;
	localparam logic [1:0] STS_NONE_READY = 2'd2;
	localparam logic [1:0] STS_NOT_BUSY   = 2'd3;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_READY = 2'd1,
		SLOT_BUSY  = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  item_kind;
		logic [15:0] customer_id;
		logic [2:0]  slot_index;
	} tsp_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  result_slot;
		logic [7:0]  result_kind;
		logic [15:0] result_customer;
	} tsp_rsp_t;

endpackage

// ===== sv/tsp_cmd_if.sv =====
// Command channel of the tagged slot pool: valid, ready and one command item.
// Depends on tsp_pkg for the item type.
interface tsp_cmd_if;
	logic             valid;
	logic             ready;
	tsp_pkg::tsp_cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/tsp_rsp_if.sv =====
// Response channel of the tagged slot pool: valid, ready and one result item.
// Depends on tsp_pkg for the item type.
interface tsp_rsp_if;
	logic             valid;
	logic             ready;
	tsp_pkg::tsp_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/tagged_slot_pool_core.sv =====
// Tagged slot pool: top level. Slot states and counts in flops, kind and
// customer of each slot in a tsp_ram. Depends on tsp_pkg, tsp_cmd_if,
// tsp_rsp_if and tsp_ram.
//
//   channel | direction | item
//   --------+-----------+-----------------------------------------------------
//   cmd     | in        | command, item_kind, customer_id, slot_index
//   rsp     | out       | status, result_slot, result_kind, result_customer
//
// Add, finish, refused and unused commands are answered in the cycle after they
// are taken; a start that finds a ready slot is answered later, as its kind and
// customer pass the RAM read register and then the response register.
// A command is taken in S_IDLE while the response register is empty or being
// emptied in the same cycle, so a waiting response stalls the command side until
// it is taken. After reset every slot is empty and both channels are idle; the
// RAM needs no clearing, since only slots written by an add are ever read.
module tagged_slot_pool_core #(
	parameter int SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	tsp_cmd_if.sink   cmd,
	tsp_rsp_if.source rsp
);
	import tsp_pkg::*;

	localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CntW  = $clog2(SLOTS + 1);
	localparam int DataW = 24;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} fsm_t;

	fsm_t              fsm_q;
	slot_state_t       state_q [SLOTS];
	logic [CntW-1:0]   free_q;
	logic [CntW-1:0]   ready_q;
	logic [SlotW-1:0]  take_slot_q;
	logic              rsp_valid_q;
	tsp_rsp_t          rsp_q;

	logic              cmd_fire;
	logic [SlotW-1:0]  empty_idx;
	logic [SlotW-1:0]  ready_idx;
	logic [SlotW-1:0]  fin_idx;
	logic              fin_ok;
	logic              ram_we;
	logic              ram_re;
	logic [DataW-1:0]  ram_rdata;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (fsm_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Lowest empty and lowest ready slot; the counts say whether one exists.
	always_comb begin
		empty_idx = '0;
		ready_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (state_q[i] == SLOT_EMPTY) begin
				empty_idx = SlotW'(i);
			end
			if (state_q[i] == SLOT_READY) begin
				ready_idx = SlotW'(i);
			end
		end
	end

	assign fin_idx = SlotW'(cmd.payload.slot_index);
	assign fin_ok  = (32'(cmd.payload.slot_index) < SLOTS) && (state_q[fin_idx] == SLOT_BUSY);

	assign ram_we = cmd_fire && (cmd.payload.command == CMD_ADD) && (free_q != '0);
	assign ram_re = cmd_fire && (cmd.payload.command == CMD_START) && (ready_q != '0);

	tsp_ram #(
		.WIDTH(DataW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(empty_idx),
		.wdata({cmd.payload.item_kind, cmd.payload.customer_id}),
		.re   (ram_re),
		.raddr(ready_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			free_q      <= CntW'(SLOTS);
			ready_q     <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				state_q[i] <= SLOT_EMPTY;
			end
		end else begin
			if (fsm_q == S_READ) begin
				// The response register was freed when the start was taken.
				rsp_valid_q <= 1'b1;
				fsm_q       <= S_IDLE;
			end else if (cmd_fire) begin
				// Only a start that finds a ready slot leaves the register empty.
				rsp_valid_q <= !((cmd.payload.command == CMD_START) && (ready_q != '0));
				case (cmd.payload.command)
					CMD_ADD: begin
						if (free_q != '0) begin
							state_q[empty_idx] <= SLOT_READY;
							free_q             <= free_q - 1'b1;
							ready_q            <= ready_q + 1'b1;
						end
					end
					CMD_START: begin
						if (ready_q != '0) begin
							state_q[ready_idx] <= SLOT_BUSY;
							ready_q            <= ready_q - 1'b1;
							fsm_q              <= S_READ;
						end
					end
					CMD_FINISH: begin
						if (fin_ok) begin
							state_q[fin_idx] <= SLOT_EMPTY;
							free_q           <= free_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fsm_q == S_READ) begin
			rsp_q.status          <= STS_OK;
			rsp_q.result_slot     <= 3'(take_slot_q);
			rsp_q.result_kind     <= ram_rdata[DataW-1:16];
			rsp_q.result_customer <= ram_rdata[15:0];
		end else if (cmd_fire) begin
			rsp_q.result_kind     <= '0;
			rsp_q.result_customer <= '0;
			case (cmd.payload.command)
				CMD_ADD: begin
					rsp_q.status      <= (free_q != '0) ? STS_OK : STS_FULL;
					rsp_q.result_slot <= (free_q != '0) ? 3'(empty_idx) : 3'd0;
				end
				CMD_START: begin
					take_slot_q       <= ready_idx;
					rsp_q.status      <= (ready_q == '0) ? STS_NONE_READY : STS_OK;
					rsp_q.result_slot <= '0;
				end
				CMD_FINISH: begin
					rsp_q.status      <= fin_ok ? STS_OK : STS_NOT_BUSY;
					rsp_q.result_slot <= '0;
				end
				default: begin
					rsp_q.status      <= STS_OK;
					rsp_q.result_slot <= '0;
				end
			endcase
		end
	end
endmodule

// ===== sv/tsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the kind and customer store of the slot pool.
module tsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/tsp_checker.sv =====
// Port-level checks for the tagged slot pool, attached by the bind below.
// Depends on tsp_pkg and on tagged_slot_pool_core for the bind target.
module tsp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input tsp_pkg::tsp_cmd_t cmd_payload,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input tsp_pkg::tsp_rsp_t rsp_payload
);
	import tsp_pkg::*;

	// A response that is not taken stays and keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response item dropped or changed while stalled");

	// A new item is only taken when the response register is free this cycle.
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && rsp_valid |-> rsp_ready)
		else $error("command item taken while a response item is stuck");

	// Everything but start answers in the next cycle.
	a_fast_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_payload.command != CMD_START |=> rsp_valid)
		else $error("no response one cycle after a command item");

	// Refused commands carry no slot, kind or customer.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != STS_OK |->
		rsp_payload.result_slot == '0 && rsp_payload.result_kind == '0 &&
		rsp_payload.result_customer == '0)
		else $error("refused response carries slot contents");
endmodule

bind tagged_slot_pool_core tsp_checker u_tsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.cmd_payload(cmd.payload),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_payload(rsp.payload)
);
